// ----- design/pmd_pkg.sv -----
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants
// Widths, register indexes and helper functions for the PID axis block.
// ----------------------------------------------------------------------------
package pmd_pkg;
    localparam int unsigned REG_PROP   = 0;
    localparam int unsigned REG_INTEG  = 1;
    localparam int unsigned REG_DERIV  = 2;
    localparam int unsigned REG_LIMIT  = 3;
    localparam int unsigned REG_PERIOD = 4;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 32;
    localparam logic [19:0] UsPerSecond = 20'd1000000;

    typedef logic signed [31:0] t_q32;
    typedef logic signed [47:0] t_q48;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [51:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic signed [52:0] quotient;
    } t_div_rsp;

    function automatic t_q32 sat32(input logic signed [63:0] v);
        t_q32 r;
        if (v > 64'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction
endpackage

// ----- design/pmd_divider.sv -----
// ----------------------------------------------------------------------------
// pmd_divider: restoring divider
// Unsigned magnitude divide, one quotient bit a cycle, sign applied at end.
// ----------------------------------------------------------------------------
module pmd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmd_pkg::t_div_req i_req,
    output pmd_pkg::t_div_rsp o_rsp
);
    logic [51:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_done;
    logic [16:0] trial;

    always_comb begin
        trial = {r_rem[15:0], r_quo[51]};
        n_quo = {r_quo[50:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem    = trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd52;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule

// ----- design/pmd_median.sv -----
// ----------------------------------------------------------------------------
// pmd_median: derivative ring and median
// Holds the ring; finds the median by counting ranks, one entry a cycle.
// ----------------------------------------------------------------------------
module pmd_median #(
    parameter int unsigned WINDOW_SIZE = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_write,
    input  pmd_pkg::t_q32 i_value,
    input  logic          i_start,
    output logic          o_done,
    output pmd_pkg::t_q32 o_median
);
    localparam int unsigned IdxW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);

    pmd_pkg::t_q32 r_win [WINDOW_SIZE];
    logic [CntW-1:0] r_fill;
    logic [IdxW-1:0] r_widx;
    logic [IdxW-1:0] r_scan;
    logic            r_busy, r_done;
    logic            r_have_lo, r_have_hi;
    pmd_pkg::t_q32   r_lo, r_hi;

    // rank of scanned entry: less-than count and less-or-equal count
    logic [CntW-1:0] lt_cnt, le_cnt;
    logic [CntW-1:0] k_lo, k_hi;
    pmd_pkg::t_q32   cand;

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        cand   = r_win[r_scan];
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            if (i < r_fill) begin
                if (r_win[i] < cand)  lt_cnt = lt_cnt + CntW'(1);
                if (r_win[i] <= cand) le_cnt = le_cnt + CntW'(1);
            end
        end
        k_hi = r_fill >> 1;
        k_lo = r_fill[0] ? k_hi : k_hi - CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_widx <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_write) begin
                if (r_fill < CntW'(WINDOW_SIZE)) begin
                    r_fill <= r_fill + CntW'(1);
                end else begin
                    r_widx <= (r_widx == IdxW'(WINDOW_SIZE - 1)) ? '0 : r_widx + IdxW'(1);
                end
            end
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (CntW'(r_scan) + CntW'(1) >= r_fill)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_write) begin
            if (r_fill < CntW'(WINDOW_SIZE)) r_win[r_fill[IdxW-1:0]] <= i_value;
            else                             r_win[r_widx] <= i_value;
        end
        if (i_start) begin
            r_scan <= '0;
            r_have_lo <= 1'b0;
            r_have_hi <= 1'b0;
        end else if (r_busy) begin
            r_scan <= r_scan + IdxW'(1);
            if (lt_cnt <= k_lo && le_cnt > k_lo) begin
                r_lo <= cand;
                r_have_lo <= 1'b1;
            end
            if (lt_cnt <= k_hi && le_cnt > k_hi) begin
                r_hi <= cand;
                r_have_hi <= 1'b1;
            end
        end
    end

    logic signed [32:0] pair_sum;
    assign pair_sum = 33'(r_lo) + 33'(r_hi);
    assign o_done   = r_done;
    assign o_median = (r_have_lo && r_have_hi) ?
                      pmd_pkg::t_q32'((pair_sum + 33'(pair_sum[32])) >>> 1) : '0;
endmodule

// ----- design/pmd_mac.sv -----
// ----------------------------------------------------------------------------
// pmd_mac: gain-term accumulator
// One 32x24 multiplier, two partial products per term, three terms.
// ----------------------------------------------------------------------------
module pmd_mac #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_step_hi,
    input  logic               i_step_lo,
    input  logic               i_finish,
    input  logic [31:0]        i_gain,
    input  logic [47:0]        i_mag,
    input  logic               i_neg,
    output logic signed [53:0] o_sum
);
    localparam logic [63:0] TermCap = 64'd1 << 50;

    logic [55:0] r_prod;
    logic [63:0] r_phi;
    logic [63:0] r_h;
    logic [63:0] q;
    logic signed [53:0] r_sum;
    logic [23:0] r_b;

    always_comb begin
        if (r_h >= (64'd1 << (26 + FRACTION_BITS))) q = TermCap;
        else q = (r_h << (24 - FRACTION_BITS)) + 64'(r_b >> FRACTION_BITS);
        if (q > TermCap) q = TermCap;
    end

    always_ff @(posedge i_clk) begin
        if (i_step_hi) r_prod <= 56'(i_gain) * 56'(i_mag[47:24]);
        if (i_step_lo) begin
            r_phi  <= 64'(r_prod);
            r_prod <= 56'(i_gain) * 56'(i_mag[23:0]);
        end
        if (i_finish) begin
            r_h <= r_phi + 64'(r_prod >> 24);
            r_b <= r_prod[23:0];
        end
    end

    // a separate accumulate strobe keeps the term pipeline one deep
    logic r_acc;
    logic r_neg;
    always_ff @(posedge i_clk) begin
        r_acc <= i_finish;
        if (i_finish) r_neg <= i_neg;
    end

    logic signed [53:0] n_sum;
    always_comb begin
        n_sum = r_sum;
        if (r_acc) n_sum = r_neg ? r_sum - 54'(q) : r_sum + 54'(q);
    end

    always_ff @(posedge i_clk) begin
        if (i_clear)    r_sum <= '0;
        else if (r_acc) r_sum <= n_sum;
    end

    assign o_sum = r_sum;
endmodule

// ----- design/pid_median_derivative_axis.sv -----
// ----------------------------------------------------------------------------
// pid_median_derivative_axis: one PID axis with median-filtered derivative
// Sequencer over a divider, rank-count median and one shared multiplier.
// ----------------------------------------------------------------------------
// One request is taken when s_axis_tready is high, which it is whenever the
// sequencer is idle; the block then drops ready and works on it. From the
// accepting edge to the result register the sequencer forms the error, starts
// the divider, waits on the bit-serial divider that forms the raw derivative,
// starts the median and waits for the rank scan (one ring entry ranked a cycle),
// runs the three gain terms, which share one multiplier two partial products at
// a time, then lands the last term and clamps. The first tick skips divide and
// median. Ready returns the cycle after the result is loaded. The result
// register parts the two sides: a new request is taken while the previous
// result waits, and the sequencer holds in its last state until the register
// is free.
module pid_median_derivative_axis #(
    parameter int unsigned WINDOW_SIZE   = 5,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write port
    input  logic          i_cfg_we,
    input  logic [pmd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [pmd_pkg::CfgDataW-1:0] i_cfg_data,
    // tdata: target[31:0], measured[63:32], elapsed_us[79:64]
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,
    // tdata: drive[31:0], clipped[32], filtered_derivative[64:33],
    //        control_error[96:65], zero pad [103:97]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_ERR = 4'd1, S_DIV = 4'd2, S_DWAIT = 4'd3,
                           S_MED = 4'd4, S_MWAIT = 4'd5, S_T0 = 4'd6, S_T1 = 4'd7,
                           S_T2 = 4'd8, S_T3 = 4'd9, S_OUT = 4'd10, S_OUT2 = 4'd11;

    // configuration
    logic [31:0] r_kp, r_ki, r_kd;
    logic [30:0] r_lim;
    logic [15:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= 32'd65536;
            r_ki     <= '0;
            r_kd     <= '0;
            r_lim    <= 31'd65536;
            r_period <= 16'd10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                3'(pmd_pkg::REG_PROP):   r_kp     <= i_cfg_data;
                3'(pmd_pkg::REG_INTEG):  r_ki     <= i_cfg_data;
                3'(pmd_pkg::REG_DERIV):  r_kd     <= i_cfg_data;
                3'(pmd_pkg::REG_LIMIT):  r_lim    <= i_cfg_data[30:0];
                3'(pmd_pkg::REG_PERIOD): r_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-tick and persistent state
    logic [3:0]          r_state;
    logic [1:0]          r_term;
    logic                r_first;
    pmd_pkg::t_q32       r_prev, r_err, r_deriv, r_tgt, r_meas;
    pmd_pkg::t_q48       r_integ;
    logic [15:0]         r_elapsed;
    logic                r_ovalid;
    logic [103:0]        r_odata;

    pmd_pkg::t_div_req   div_req;
    pmd_pkg::t_div_rsp   div_rsp;
    logic                med_write, med_start, med_done;
    pmd_pkg::t_q32       med_out;
    logic                mac_clear, mac_hi, mac_lo, mac_fin;
    logic [31:0]         mac_gain;
    logic [47:0]         mac_mag;
    logic                mac_neg;
    logic signed [53:0]  mac_sum;

    logic [15:0] period;
    logic [15:0] dt;
    logic [17:0] e2, p3;
    logic [19:0] e10, p7;
    logic signed [32:0] diff;
    logic [32:0] diff_mag;
    logic signed [48:0] integ_next;
    pmd_pkg::t_q48 integ_sat;
    pmd_pkg::t_q32 raw;

    always_comb begin
        period = (r_period == '0) ? 16'd1 : r_period;
        e2  = {1'b0, r_elapsed, 1'b0};
        p3  = 18'(period) + 18'({period, 1'b0});
        e10 = 20'({r_elapsed, 3'b0}) + 20'({r_elapsed, 1'b0});
        p7  = 20'({period, 3'b0}) - 20'(period);
        dt  = (e2 > p3 || e10 < p7) ? period : r_elapsed;
        diff = 33'(r_err) - 33'(r_prev);
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        integ_next = 49'(r_integ) + 49'(r_err);
        if (integ_next > 49'sd140737488355327)       integ_sat = 48'sh7FFFFFFFFFFF;
        else if (integ_next < -49'sd140737488355328) integ_sat = 48'sh800000000000;
        else                                         integ_sat = integ_next[47:0];
        raw = pmd_pkg::sat32(64'(div_rsp.quotient));
        div_req.start    = (r_state == S_DIV);
        div_req.neg      = diff[32];
        div_req.dividend = 52'(diff_mag) * 52'(pmd_pkg::UsPerSecond);
        div_req.divisor  = dt;
        med_write = (r_state == S_DWAIT) && div_rsp.done;
        med_start = (r_state == S_MED);
    end

    // term selection: 0 prop, 1 integral, 2 derivative
    always_comb begin
        case (r_term)
            2'd0: begin mac_gain = r_kp; mac_mag = 48'(r_err);   end
            2'd1: begin mac_gain = r_ki; mac_mag = 48'(r_integ); end
            default: begin mac_gain = r_kd; mac_mag = 48'(r_deriv); end
        endcase
        mac_neg = mac_mag[47];
        if (mac_neg) mac_mag = -mac_mag;
        mac_clear = (r_state == S_T0) && (r_term == 2'd0);
        mac_hi    = (r_state == S_T1);
        mac_lo    = (r_state == S_T2);
        mac_fin   = (r_state == S_T3);
    end

    pmd_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

    pmd_median #(.WINDOW_SIZE(WINDOW_SIZE)) u_med (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_write(med_write), .i_value(raw),
        .i_start(med_start), .o_done(med_done), .o_median(med_out)
    );

    pmd_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
        .i_clk(i_clk), .i_clear(mac_clear), .i_step_hi(mac_hi), .i_step_lo(mac_lo),
        .i_finish(mac_fin), .i_gain(mac_gain), .i_mag(mac_mag), .i_neg(mac_neg),
        .o_sum(mac_sum)
    );

    logic signed [53:0] lim_w;
    logic               out_load;
    assign lim_w = 54'(r_lim);
    assign s_axis_tready = (r_state == S_IDLE);
    // result register free now or emptied at this edge
    assign out_load = (r_state == S_OUT2) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= 1'b1;
            r_prev   <= '0;
            r_integ  <= '0;
            r_ovalid <= 1'b0;
            r_term   <= '0;
        end else begin
            if (out_load)           r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_tgt     <= s_axis_tdata[31:0];
                    r_meas    <= s_axis_tdata[63:32];
                    r_elapsed <= s_axis_tdata[79:64];
                    r_state   <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= pmd_pkg::sat32(64'(r_tgt) - 64'(r_meas));
                    r_state <= r_first ? S_T0 : S_DIV;
                    r_deriv <= '0;
                    r_term  <= '0;
                end
                S_DIV:   r_state <= S_DWAIT;
                S_DWAIT: if (div_rsp.done) r_state <= S_MED;
                S_MED:   r_state <= S_MWAIT;
                S_MWAIT: if (med_done) begin
                    r_deriv <= med_out;
                    r_state <= S_T0;
                end
                S_T0: begin
                    if (r_term == 2'd0) begin
                        r_integ <= integ_sat;
                        r_first <= 1'b0;
                    end
                    r_state <= S_T1;
                end
                S_T1: r_state <= S_T2;
                S_T2: r_state <= S_T3;
                S_T3: begin
                    if (r_term == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_term  <= r_term + 2'd1;
                        r_state <= S_T0;
                    end
                end
                S_OUT: r_state <= S_OUT2; // last accumulate lands
                S_OUT2: if (out_load) begin
                    r_prev   <= r_err;
                    r_odata[103:97] <= '0;
                    r_odata[96:65]  <= r_err;
                    r_odata[64:33]  <= r_deriv;
                    if (mac_sum > lim_w) begin
                        r_odata[31:0] <= 32'(r_lim);
                        r_odata[32]   <= 1'b1;
                    end else if (mac_sum < -lim_w) begin
                        r_odata[31:0] <= 32'(-lim_w);
                        r_odata[32]   <= 1'b1;
                    end else begin
                        r_odata[31:0] <= mac_sum[31:0];
                        r_odata[32]   <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

// ----- verif/tb_pid_median_derivative_axis.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_median_derivative_axis: self-checking bench for one PID axis
// Streams control ticks through the block under several gain, limit and
// period settings, predicts each result and checks drive, clip flag,
// filtered derivative and error field by field.
// ----------------------------------------------------------------------------
module tb_pid_median_derivative_axis;

    localparam int NWIN = 5;
    localparam int FRAC = 16;

    typedef struct packed {
        logic [31:0] ctl_err;
        logic [31:0] deriv;
        logic        clip;
        logic [31:0] drive;
    } t_result;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the axis state copy and the queue of awaited results
    // ------------------------------------------------------------------------
    class pid_scoreboard;
        bit [31:0] kp, ki, kd;
        bit [30:0] lim;
        bit [15:0] period;
        longint    prev_err, integ;
        longint    ring[NWIN];
        int        fill, wr_idx;
        bit        first;
        t_result   awaited[$];
        int        n_err, n_checked;

        function void clear_state();
            kp = 65536; ki = 0; kd = 0; lim = 65536; period = 10000;
            prev_err = 0; integ = 0; fill = 0; wr_idx = 0; first = 1;
            n_err = 0; n_checked = 0;
        endfunction

        function void write_reg(int idx, bit [31:0] v);
            case (idx)
                pmd_pkg::REG_PROP:   kp = v;
                pmd_pkg::REG_INTEG:  ki = v;
                pmd_pkg::REG_DERIV:  kd = v;
                pmd_pkg::REG_LIMIT:  lim = v[30:0];
                pmd_pkg::REG_PERIOD: period = v[15:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // gain * x scaled by the fraction, magnitude capped at 2^50
        function longint scaled_term(bit [31:0] g, longint x);
            logic [47:0]  m;
            logic [79:0]  p;
            logic [79:0]  q;
            m = 48'((x < 0) ? -x : x);
            p = g * m;
            q = p >> FRAC;
            if (q > (80'd1 << 50)) q = 80'd1 << 50;
            return (x < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint median_of_ring();
            longint s[NWIN];
            longint v;
            int j;
            for (int i = 0; i < fill; i++) s[i] = ring[i];
            for (int i = 1; i < fill; i++) begin
                v = s[i]; j = i;
                while (j > 0 && s[j-1] > v) begin
                    s[j] = s[j-1]; j--;
                end
                s[j] = v;
            end
            if (fill % 2) return s[fill/2];
            return (s[fill/2-1] + s[fill/2]) / 2;
        endfunction

        function void note_tick(bit [31:0] tgt, bit [31:0] meas, bit [15:0] el);
            longint p, dt, err, raw, deriv, sum, l;
            t_result r;
            p = (period == 0) ? 1 : period;
            err = clip32(longint'($signed(tgt)) - longint'($signed(meas)));
            deriv = 0;
            if (first || 2*longint'(el) > 3*p || 10*longint'(el) < 7*p) dt = p;
            else dt = el;
            if (first) first = 0;
            else begin
                raw = clip32((err - prev_err) * 1000000 / dt);
                if (fill < NWIN) begin
                    ring[fill] = raw; fill++;
                end else begin
                    ring[wr_idx] = raw; wr_idx = (wr_idx + 1) % NWIN;
                end
                deriv = median_of_ring();
            end
            integ = integ + err;
            if (integ > (64'sd1 <<< 47) - 1) integ = (64'sd1 <<< 47) - 1;
            if (integ < -(64'sd1 <<< 47)) integ = -(64'sd1 <<< 47);
            prev_err = err;
            sum = scaled_term(kp, err) + scaled_term(ki, integ) + scaled_term(kd, deriv);
            l = lim;
            r.clip = 0;
            if (sum > l) begin
                sum = l; r.clip = 1;
            end else if (sum < -l) begin
                sum = -l; r.clip = 1;
            end
            r.drive = sum[31:0];
            r.deriv = deriv[31:0];
            r.ctl_err = err[31:0];
            awaited = {awaited, r};
        endfunction

        task check_result(t_result got);
            t_result w;
            n_checked++;
            if (awaited.size() == 0) begin
                report("unexpected result", 0, got.drive);
                return;
            end
            w = awaited.pop_front();
            if (got.drive !== w.drive) report("drive", w.drive, got.drive);
            if (got.clip !== w.clip) report("clipped", w.clip, got.clip);
            if (got.deriv !== w.deriv) report("filtered_derivative", w.deriv, got.deriv);
            if (got.ctl_err !== w.ctl_err) report("control_error", w.ctl_err, got.ctl_err);
        endtask

        task report(string what, bit [31:0] want, bit [31:0] got);
            n_err++;
            if (n_err <= 30)
                $display("mismatch %0s on result %0d: want %h got %h",
                         what, n_checked, want, got);
        endtask
    endclass

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_we = 0;
    logic [2:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [79:0]   s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [103:0]  m_axis_tdata;

    pid_scoreboard sb;
    int            n_ticks;

    pid_median_derivative_axis dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // one request on the slave side; waits for the handshake. tvalid stays up
    // after it (block is busy) until the next gap or wait_idle drops it.
    task automatic send_tick(bit [31:0] tgt, bit [31:0] meas, bit [15:0] el);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {el, meas, tgt};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(tgt, meas, el);
        n_ticks++;
    endtask

    task automatic write_cfg(int idx, bit [31:0] v);
        i_cfg_we    <= 1;
        i_cfg_index <= idx[2:0];
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // block is idle once nothing is awaited
    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // receiver: random back-pressure, checks every accepted result
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(t_result'(m_axis_tdata[96:0]));
        end
    end

    function automatic bit [31:0] rand_val(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        endcase
    endfunction

    function automatic bit [15:0] rand_elapsed(bit [15:0] p);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'(p * 7 / 10 + $urandom_range(0, p * 8 / 10 + 1));
        return 16'($urandom_range(0, 16'hffff));
    endfunction

    // one phase: program all registers, then random ticks around a trajectory
    task automatic run_phase(bit [31:0] kp, bit [31:0] ki, bit [31:0] kd,
                             bit [31:0] lim, bit [31:0] per, int count, int mode);
        bit [31:0] tgt, meas;
        write_cfg(pmd_pkg::REG_PROP, kp);
        write_cfg(pmd_pkg::REG_INTEG, ki);
        write_cfg(pmd_pkg::REG_DERIV, kd);
        write_cfg(pmd_pkg::REG_LIMIT, lim);
        write_cfg(pmd_pkg::REG_PERIOD, per);
        tgt = rand_val(mode);
        meas = rand_val(mode);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                tgt = rand_val(0); meas = rand_val(0);
            end else begin
                tgt  = tgt + rand_val(2) / 64;
                meas = meas + rand_val(2) / 64;
            end
            send_tick(tgt, meas, rand_elapsed(sb.period == 0 ? 1 : sb.period));
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        n_ticks = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset gains, first tick, field extremes, period window edges
        send_tick(32'h7fff_ffff, 32'h8000_0000, 16'd0);      // error saturates high
        send_tick(32'h8000_0000, 32'h7fff_ffff, 16'hffff);   // and low, big step
        send_tick(32'h0001_0000, 32'h0, 16'd7000);           // 0.7 of nominal
        send_tick(32'h0002_0000, 32'h0, 16'd6999);           // just under the window
        send_tick(32'h0, 32'h0001_0000, 16'd15000);          // 1.5 of nominal
        send_tick(32'h0, 32'h0003_0000, 16'd15001);          // just over
        send_tick(32'hffff_ffff, 32'h0, 16'd10000);
        send_tick(32'h0, 32'h0, 16'd10000);                  // ring already wrapped
        send_tick(32'h1234_5678, 32'hedcb_a987, 16'd12000);
        wait_idle();
        // strong integral and derivative, period register at zero and at maximum
        write_cfg(pmd_pkg::REG_INTEG, 32'hffff_ffff);
        write_cfg(pmd_pkg::REG_DERIV, 32'hffff_ffff);
        write_cfg(pmd_pkg::REG_PERIOD, 32'h0);
        write_cfg(pmd_pkg::REG_LIMIT, 32'h7fff_ffff);
        write_cfg(7, 32'hdead_beef);                         // unused index, ignored
        for (int i = 0; i < 6; i++)
            send_tick(i[0] ? 32'h7fff_ffff : 32'h8000_0000, 32'h0, 16'd1);
        wait_idle();
        write_cfg(pmd_pkg::REG_PERIOD, 32'hffff_ffff);
        write_cfg(pmd_pkg::REG_PROP, 32'h0);
        send_tick(32'h0000_8000, 32'h0, 16'hffff);
        send_tick(32'h0, 32'h0000_8000, 16'd50000);
        wait_idle();

        // random phases across settings; state carries on between them
        run_phase(32'h0001_0000, 32'h0000_0100, 32'h0000_0400, 32'h0010_0000, 10000, 300, 1);
        run_phase(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 65535, 200, 0);
        run_phase(32'h0, 32'h0, 32'h0, 32'h0, 1, 150, 1);
        run_phase($urandom(), $urandom(), $urandom(), $urandom() >> 1, 1000, 350, 2);
        run_phase($urandom() >> 12, $urandom() >> 16, $urandom() >> 14,
                  $urandom_range(0, 32'h0100_0000), $urandom_range(1, 65535), 300, 1);
        run_phase(32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000, 2500, 300, 2);

        $display("ran %0d ticks over directed and random register settings, %0d results checked",
                 n_ticks, sb.n_checked);
        $display("covered saturated errors, step-time fallback, ring fill and wrap, clamping");
        if (sb.n_err == 0 && sb.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // about 1600 ticks plus long gaps on both sides fit well inside this
    initial begin
        #20_000_000;
        $display("timeout with %0d results awaited", sb.awaited.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule
